FILE: sv/gdsp_pkg.sv
`default_nettype none
package gdsp_pkg;
    localparam int NumServos    = 24;
    localparam int PayloadBytes = 128;
    localparam int ChW          = $clog2(NumServos);
    localparam int CntW         = $clog2(NumServos + 1);
    localparam int LenW         = $clog2(PayloadBytes);

    localparam logic [1:0] RegThreshold = 2'd0;
    localparam logic [1:0] RegPulseMin  = 2'd1;
    localparam logic [1:0] RegPulseMax  = 2'd2;
    localparam logic [1:0] RegTimeout   = 2'd3;

    localparam logic [1:0] PhWs     = 2'd0;
    localparam logic [1:0] PhSign   = 2'd1;
    localparam logic [1:0] PhDigits = 2'd2;
    localparam logic [1:0] PhStop   = 2'd3;

    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChComma   = 8'h2C;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [4:0]  channel;
        logic [11:0] pulse;
        logic        last;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic          load;
        logic          home;
        logic [ChW-1:0] idx;
        logic          start_div;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic run;
        logic home;
        logic div_done;
    } t_sts;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] p);
        logic [7:0] r;
        unique case (p)
            3'd0:    r = 8'h47;
            3'd1:    r = 8'h52;
            3'd2:    r = 8'h49;
            3'd3:    r = 8'h44;
            default: r = 8'h3A;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: sv/grid_depth_to_servo_pulse.sv
`default_nettype none
// Parses "GRID:" text lines and millisecond ticks one transaction at a time. A byte or
// tick is accepted whenever no pulse run is in progress. A valid line with 24
// values, or a failsafe timeout tick, starts a run of 24 result transactions; each
// channel is computed by the 20-step serial divider of the interpolation and can be
// held by an output stall. Input is not accepted while a run is in progress.
module grid_depth_to_servo_pulse (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire gdsp_pkg::t_in   i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output gdsp_pkg::t_out       o_data,
    input  wire logic            i_cfg_we,
    input  wire logic [1:0]      i_cfg_idx,
    input  wire logic [15:0]     i_cfg_data
);
    import gdsp_pkg::*;

    t_cmd        cmd;
    t_sts        sts;
    logic [11:0] pulse;
    logic        idle, acc;

    assign acc = i_valid && o_ready;

    gdsp_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_byte_valid(acc && !i_data.req_type),
        .i_tick_valid(acc && i_data.req_type),
        .i_byte(i_data.rx_byte),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .o_sts(sts), .o_pulse(pulse)
    );

    gdsp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_sts(sts), .i_pulse(pulse),
        .i_out_ready(i_ready), .o_cmd(cmd), .o_idle(idle),
        .o_out_valid(o_valid), .o_out(o_data)
    );

    assign o_ready = idle;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.run |=> !o_ready) else $error("input taken during run");
    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.last |-> o_data.channel == 5'(NumServos - 1))
        else $error("last flag on wrong channel");
    a_idle_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready && o_valid |-> o_data.last) else $error("output pending while idle");
endmodule
`default_nettype wire

FILE: sv/gdsp_datapath.sv
`default_nettype none
module gdsp_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_byte_valid,
    input  wire logic                 i_tick_valid,
    input  wire logic [7:0]           i_byte,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [15:0]          i_cfg_data,
    input  wire gdsp_pkg::t_cmd       i_cmd,
    output gdsp_pkg::t_sts            o_sts,
    output logic [11:0]               o_pulse
);
    import gdsp_pkg::*;

    logic [7:0]  r_thr;
    logic [11:0] r_pmin, r_pmax;
    logic [15:0] r_tmo;
    logic [2:0]  r_hpos;
    logic        r_rej;
    logic [8:0]  r_acc;
    logic        r_neg;
    logic [1:0]  r_ph;
    logic        r_nb;
    logic [CntW-1:0] r_cnt;
    logic [LenW-1:0] r_len;
    logic [15:0] r_ms;
    logic [7:0]  r_store [NumServos];

    logic [8:0]  n_acc;
    logic        n_neg;
    logic [1:0]  n_ph;
    logic        n_nb;
    logic        commit_now;
    logic [7:0]  commit_val;
    logic        line_ok, final_commit;
    logic        tok_clear;
    logic        pay_take;

    logic [3:0]  d10;
    logic        is_dig;
    logic [12:0] acc10;

    assign d10    = 4'(i_byte - 8'h30);
    assign is_dig = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign acc10  = {r_acc, 3'b0} + {3'b0, r_acc, 1'b0} + {9'd0, d10};

    assign commit_val = (r_ph == PhDigits && !r_neg) ?
                        ((r_acc > 9'd255) ? 8'd255 : r_acc[7:0]) : 8'd0;

    assign pay_take = i_byte_valid && i_byte != ChNewline && !r_rej && r_hpos == 3'd5
                      && r_len != LenW'(PayloadBytes - 1)
                      && !(r_len == '0 && is_ws(i_byte));

    // Token parser next state.
    always_comb begin
        n_acc = r_acc;
        n_neg = r_neg;
        n_ph  = r_ph;
        n_nb  = 1'b1;
        commit_now = 1'b0;
        tok_clear  = 1'b0;
        if (i_byte == ChComma) begin
            commit_now = r_nb;
            tok_clear  = 1'b1;
        end else begin
            unique case (r_ph)
                PhWs: begin
                    if (is_ws(i_byte)) begin
                        n_ph = PhWs;
                    end else if (i_byte == 8'h2B || i_byte == 8'h2D) begin
                        n_neg = (i_byte == 8'h2D);
                        n_ph  = PhSign;
                    end else if (is_dig) begin
                        n_acc = {5'd0, d10};
                        n_ph  = PhDigits;
                    end else begin
                        n_ph = PhStop;
                    end
                end
                PhSign: begin
                    if (is_dig) begin
                        n_acc = {5'd0, d10};
                        n_ph  = PhDigits;
                    end else begin
                        n_ph = PhStop;
                    end
                end
                PhDigits: begin
                    if (is_dig) begin
                        n_acc = (acc10 > 13'd256) ? 9'd256 : acc10[8:0];
                    end else begin
                        n_ph = PhStop;
                    end
                end
                default: n_ph = PhStop;
            endcase
        end
    end

    assign final_commit = !r_rej && r_hpos == 3'd5 && r_nb && r_ph != PhWs;
    assign line_ok = !r_rej && r_hpos == 3'd5 &&
                     ((final_commit && r_cnt < CntW'(NumServos)) ? (r_cnt + 1'b1)
                                                                 : r_cnt) == CntW'(NumServos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 8'd20;
            r_pmin <= 12'd250;
            r_pmax <= 12'd490;
            r_tmo <= 16'd2000;
            r_hpos <= '0; r_rej <= 1'b0; r_acc <= '0; r_neg <= 1'b0;
            r_ph <= PhWs; r_nb <= 1'b0; r_cnt <= '0; r_len <= '0; r_ms <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    RegThreshold: r_thr  <= i_cfg_data[7:0];
                    RegPulseMin:  r_pmin <= i_cfg_data[11:0];
                    RegPulseMax:  r_pmax <= i_cfg_data[11:0];
                    default:      r_tmo  <= i_cfg_data;
                endcase
            end
            if (i_tick_valid) begin
                if (r_ms >= r_tmo) r_ms <= '0;
                else r_ms <= r_ms + 16'd1;
            end else if (i_byte_valid) begin
                if (i_byte == ChNewline) begin
                    if (line_ok) r_ms <= '0;
                    r_hpos <= '0; r_rej <= 1'b0; r_cnt <= '0; r_len <= '0;
                    r_acc <= '0; r_neg <= 1'b0; r_ph <= PhWs; r_nb <= 1'b0;
                end else if (!r_rej && r_hpos != 3'd5) begin
                    if (!(r_hpos == 3'd0 && is_ws(i_byte))) begin
                        if (i_byte == hdr_char(r_hpos)) r_hpos <= r_hpos + 3'd1;
                        else r_rej <= 1'b1;
                    end
                end else if (pay_take) begin
                    r_len <= r_len + 1'b1;
                    if (commit_now && r_cnt < CntW'(NumServos)) r_cnt <= r_cnt + 1'b1;
                    if (tok_clear) begin
                        r_acc <= '0; r_neg <= 1'b0; r_ph <= PhWs; r_nb <= 1'b0;
                    end else begin
                        r_acc <= n_acc; r_neg <= n_neg; r_ph <= n_ph; r_nb <= n_nb;
                    end
                end
            end
        end
    end

    // Value store, written as each value is committed; a timeout run can read it before any write.
    always_ff @(posedge i_clk) begin
        if (i_byte_valid && r_cnt < CntW'(NumServos) &&
            ((pay_take && commit_now) ||
             (i_byte == ChNewline && final_commit))) begin
            r_store[r_cnt[ChW-1:0]] <= commit_val;
        end
    end

    assign o_sts.run  = i_byte_valid && i_byte == ChNewline && line_ok;
    assign o_sts.home = i_tick_valid && r_ms >= r_tmo;

    // Per-channel interpolation with a restoring divider.
    logic [7:0]  r_v;
    logic        r_lo, r_hm, r_full, r_inv;
    logic [19:0] r_num;
    logic [11:0] r_q;
    logic [8:0]  r_rem;
    logic [4:0]  r_bit;
    logic        r_busy;
    logic [11:0] span_p;
    logic [7:0]  span;
    logic [9:0]  trial;
    logic [11:0] pulse_c;

    assign span   = 8'd255 - r_thr;
    assign span_p = (r_pmax >= r_pmin) ? (r_pmax - r_pmin) : (r_pmin - r_pmax);
    assign trial  = {r_rem, r_num[19]} - {2'b0, span};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_v <= r_store[i_cmd.idx];
    end

    // The finished quotient holds until the next start, so done stays up
    // while the controller waits for the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_bit  <= '0;
        end else if (i_cmd.start_div) begin
            r_busy <= 1'b1;
            r_bit  <= 5'd20;
            r_hm   <= i_cmd.home;
            r_lo   <= r_v < r_thr;
            r_full <= r_thr == 8'd255;
            r_inv  <= r_pmax < r_pmin;
            r_num  <= 20'(r_v - r_thr) * 20'(span_p);
            r_rem  <= '0;
            r_q    <= '0;
        end else if (r_busy && r_bit != 5'd0) begin
            r_bit <= r_bit - 5'd1;
            r_num <= {r_num[18:0], 1'b0};
            if (!trial[9]) begin
                r_rem <= trial[8:0];
                r_q   <= {r_q[10:0], 1'b1};
            end else begin
                r_rem <= {r_rem[7:0], r_num[19]};
                r_q   <= {r_q[10:0], 1'b0};
            end
        end
    end

    assign o_sts.div_done = r_busy && r_bit == 5'd0;

    always_comb begin
        if (r_hm || r_lo) pulse_c = r_pmin;
        else if (r_full) pulse_c = r_pmax;
        else if (r_inv) pulse_c = r_pmin - r_q;
        else pulse_c = r_pmin + r_q;
    end
    assign o_pulse = pulse_c;
endmodule
`default_nettype wire

FILE: sv/gdsp_ctrl.sv
`default_nettype none
module gdsp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gdsp_pkg::t_sts i_sts,
    input  wire logic [11:0]    i_pulse,
    input  wire logic           i_out_ready,
    output gdsp_pkg::t_cmd      o_cmd,
    output logic                o_idle,
    output logic                o_out_valid,
    output gdsp_pkg::t_out      o_out
);
    import gdsp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_DIV  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [ChW-1:0] r_idx;
    logic           r_home;
    t_out           r_out;
    logic           r_ov;

    always_comb begin
        n_state = r_state;
        o_cmd.load = 1'b0;
        o_cmd.start_div = 1'b0;
        o_cmd.home = r_home;
        o_cmd.idx = r_idx;
        unique case (r_state)
            S_IDLE: if (i_sts.run || i_sts.home) n_state = S_LOAD;
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.start_div = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: if (i_sts.div_done && (!r_ov || i_out_ready)) n_state = S_OUT;
            default: begin
                if (r_idx == ChW'(NumServos - 1)) n_state = S_IDLE;
                else n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_home  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_idx  <= '0;
                r_home <= i_sts.home;
            end
            if (r_state == S_OUT) r_idx <= r_idx + 1'b1;
            if (r_state == S_WAIT && n_state == S_OUT) r_ov <= 1'b1;
            else if (i_out_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && n_state == S_OUT) begin
            r_out.channel <= 5'(r_idx);
            r_out.pulse   <= i_pulse;
            r_out.last    <= r_idx == ChW'(NumServos - 1);
        end
    end

    assign o_idle      = r_state == S_IDLE;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;
endmodule
`default_nettype wire
